FILE: design/abih_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abih_pkg
// Types and constants shared by the angle-binned histogram block.
// ----------------------------------------------------------------------------
package abih_pkg;

  localparam int unsigned MAX_BINS_DEF = 1024;
  localparam int unsigned SUM_W        = 48;
  localparam int unsigned CNT_W        = 24;
  localparam int unsigned ANG_W        = 24;
  localparam int unsigned INT_W        = 24;
  localparam int unsigned CORR_W       = 16;
  localparam int unsigned SCL_W        = 16;
  localparam int unsigned NB_W         = 11;
  localparam int unsigned RBIN_W       = 10;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DAT_W    = 24;
  localparam int unsigned BIN_W        = 18;  // (24b * 24b) >> 30
  localparam int unsigned CORR_FRAC    = 14;
  localparam int unsigned ANG_SHIFT    = 30;
  localparam int unsigned DVD_W        = 56;  // (sum * scale) >> 8

  localparam logic [1:0] OP_ACCUM    = 2'd0;
  localparam logic [1:0] OP_READ     = 2'd1;
  localparam logic [1:0] OP_READ_CLR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_EN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_SCALE   = 3'd4;

  typedef struct packed {
    logic [1:0]        op;
    logic [INT_W-1:0]  intensity;
    logic              intensity_nan;
    logic              correction_used;
    logic [CORR_W-1:0] correction;
    logic              correction_nan;
    logic [ANG_W-1:0]  angle;
    logic [RBIN_W-1:0] read_bin;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] bin_sum;
    logic [CNT_W-1:0] bin_count;
    logic [SUM_W-1:0] bin_value;
  } out_item_t;

endpackage

`default_nettype wire

FILE: design/abih_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abih_if
// Valid/ready channels of the histogram block: items in, results out, config.
// ----------------------------------------------------------------------------
interface abih_in_if;
  logic               valid;
  logic               ready;
  abih_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface abih_out_if;
  logic                valid;
  logic                ready;
  abih_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface abih_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [abih_pkg::CFG_IDX_W-1:0]      index;
  logic [abih_pkg::CFG_DAT_W-1:0]      wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: design/angle_binned_intensity_histogram.sv
`timescale 1ns / 1ps
`default_nettype none
// Accumulate item: multiply, bin address + RAM read, then read-modify-write.
// Read item: RAM read, then result (straight to the result if the index is beyond
// the store); an averaged read adds the S_MLO/S_MHI multiply and a bit-serial divider.
// Skipped pixels and unused op codes leave the block idle. One item in flight at a time.
// After reset all MAX_BINS bin RAM entries are cleared with in_ch.ready low;
// config writes are taken throughout.
// ----------------------------------------------------------------------------
// angle_binned_intensity_histogram
// Weighted histogram over scattering angle, bins held in one RAM.
// ----------------------------------------------------------------------------
module angle_binned_intensity_histogram #(
  parameter int unsigned MAX_BINS = abih_pkg::MAX_BINS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  abih_in_if.sink    in_ch,
  abih_out_if.source out_ch,
  abih_cfg_if.sink   cfg_ch
);
  localparam int unsigned AW  = $clog2(MAX_BINS);
  localparam int unsigned RW  = abih_pkg::SUM_W + abih_pkg::CNT_W;
  localparam int unsigned NEW = AW + 1;
  localparam int unsigned SW  = abih_pkg::SUM_W;
  localparam int unsigned CW  = abih_pkg::CNT_W;
  localparam int unsigned VW  = abih_pkg::INT_W + abih_pkg::CORR_W;
  localparam int unsigned PHW = SW + abih_pkg::SCL_W - CW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ADDR  = 4'd2;
  localparam logic [3:0] S_RMW   = 4'd3;
  localparam logic [3:0] S_RDATA = 4'd4;
  localparam logic [3:0] S_MLO   = 4'd5;
  localparam logic [3:0] S_MHI   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // config registers
  logic [abih_pkg::ANG_W-1:0]  min_angle_r;
  logic [abih_pkg::ANG_W-1:0]  bin_scale_r;
  logic [abih_pkg::NB_W-1:0]   num_bins_r;
  logic                        avg_en_r;
  logic [abih_pkg::SCL_W-1:0]  int_scale_r;

  logic [3:0]               state_r;
  logic                     clr_act_r;
  logic [AW-1:0]            clr_addr_r;
  abih_pkg::in_item_t       item_r;
  logic [VW-1:0]            prod_corr_r;
  logic [2*abih_pkg::ANG_W-1:0] prod_ang_r;
  logic                     below_r;
  logic [AW-1:0]            addr_r;
  logic [VW-1:0]            val_r;
  logic [SW-1:0]            sum_r;
  logic [CW-1:0]            cnt_r;
  logic [SW-1:0]            value_r;
  logic [VW-1:0]            mlo_r;
  logic [CW:0]              rem_r;
  logic [abih_pkg::DVD_W-1:0] dvd_r;
  logic [5:0]               step_r;
  logic                     out_valid_r;
  abih_pkg::out_item_t      out_data_r;

  logic                     in_acc;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [RW-1:0]            ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [RW-1:0]            ram_rdata;
  logic                     rd_oob;
  logic [NEW-1:0]           nb_eff;
  logic [AW-1:0]            last_bin;
  logic [abih_pkg::BIN_W-1:0] bin_raw;
  logic [AW-1:0]            bin_sel;
  logic [SW:0]              sum_add;
  logic [SW-1:0]            sum_new;
  logic [CW-1:0]            cnt_new;
  logic [CW:0]              trial;
  logic                     qbit;
  logic [SW+abih_pkg::SCL_W-1:0] num_full;
  logic                     out_free;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE) && !clr_act_r;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign rd_oob = {{(32-abih_pkg::RBIN_W){1'b0}}, in_ch.data.read_bin} >= 32'(MAX_BINS);

  // bins in use: num_bins, 0 acts as 1, capped at MAX_BINS
  always_comb begin
    priority if (num_bins_r == '0) begin
      nb_eff = NEW'(1);
    end else if (32'(num_bins_r) > 32'(MAX_BINS)) begin
      nb_eff = NEW'(MAX_BINS);
    end else begin
      nb_eff = NEW'(num_bins_r);
    end
  end
  assign last_bin = AW'(nb_eff - NEW'(1));
  assign bin_raw  = below_r ? '0 : prod_ang_r[abih_pkg::ANG_SHIFT +: abih_pkg::BIN_W];
  assign bin_sel  = (32'(bin_raw) > 32'(last_bin)) ? last_bin : AW'(bin_raw);

  assign sum_add = {1'b0, ram_rdata[RW-1 -: SW]} + (SW+1)'(val_r);
  assign sum_new = sum_add[SW] ? '1 : sum_add[SW-1:0];
  assign cnt_new = (ram_rdata[CW-1:0] == '1) ? '1 : ram_rdata[CW-1:0] + CW'(1);

  assign trial = {rem_r[CW-1:0], dvd_r[abih_pkg::DVD_W-1]};
  assign qbit  = trial >= {1'b0, cnt_r};
  assign num_full = {(PHW'(sum_r[SW-1 -: CW]) * PHW'(int_scale_r)), {CW{1'b0}}}
                  + (SW+abih_pkg::SCL_W)'(mlo_r);

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = {sum_new, cnt_new};
    ram_re    = 1'b0;
    ram_raddr = AW'(in_ch.data.read_bin);
    if (clr_act_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (state_r == S_RMW) begin
      ram_we = 1'b1;
    end else if (state_r == S_RDATA && item_r.op == abih_pkg::OP_READ_CLR) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
    end
    if (state_r == S_ADDR) begin
      ram_re    = 1'b1;
      ram_raddr = bin_sel;
    end else if (in_acc) begin
      ram_re = 1'b1;
    end
  end

  abih_ram #(.WIDTH(RW), .DEPTH(MAX_BINS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_angle_r <= '0;
      bin_scale_r <= abih_pkg::ANG_W'(65536);
      num_bins_r  <= abih_pkg::NB_W'(1024);
      avg_en_r    <= 1'b0;
      int_scale_r <= abih_pkg::SCL_W'(256);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        abih_pkg::REG_MIN_ANGLE: min_angle_r <= cfg_ch.wdata;
        abih_pkg::REG_BIN_SCALE: bin_scale_r <= cfg_ch.wdata;
        abih_pkg::REG_NUM_BINS:  num_bins_r  <= cfg_ch.wdata[abih_pkg::NB_W-1:0];
        abih_pkg::REG_AVG_EN:    avg_en_r    <= cfg_ch.wdata[0];
        abih_pkg::REG_INT_SCALE: int_scale_r <= cfg_ch.wdata[abih_pkg::SCL_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_act_r   <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (clr_act_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (32'(clr_addr_r) == MAX_BINS - 1) begin
          clr_act_r <= 1'b0;
        end
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_ch.data.op)
              abih_pkg::OP_ACCUM: begin
                if (!in_ch.data.intensity_nan &&
                    !(in_ch.data.correction_used && in_ch.data.correction_nan)) begin
                  state_r <= S_MUL;
                end
              end
              abih_pkg::OP_READ, abih_pkg::OP_READ_CLR: begin
                state_r <= rd_oob ? S_OUT : S_RDATA;
              end
              default: ;
            endcase
          end
        end
        S_MUL:   state_r <= S_ADDR;
        S_ADDR:  state_r <= S_RMW;
        S_RMW:   state_r <= S_IDLE;
        S_RDATA: begin
          state_r <= (avg_en_r && ram_rdata[CW-1:0] != '0) ? S_MLO : S_OUT;
        end
        S_MLO:   state_r <= S_MHI;
        S_MHI: begin
          state_r <= S_DIV;
          step_r  <= '0;
        end
        S_DIV: begin
          step_r <= step_r + 6'd1;
          if (step_r == 6'(abih_pkg::DVD_W - 1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r  <= in_ch.data;
      addr_r  <= AW'(in_ch.data.read_bin);
      sum_r   <= '0;
      cnt_r   <= '0;
      value_r <= '0;
    end
    unique case (state_r)
      S_MUL: begin
        prod_corr_r <= item_r.intensity * item_r.correction;
        below_r     <= item_r.angle < min_angle_r;
        prod_ang_r  <= (item_r.angle - min_angle_r) * bin_scale_r;
      end
      S_ADDR: begin
        addr_r <= bin_sel;
        val_r  <= item_r.correction_used ? (prod_corr_r >> abih_pkg::CORR_FRAC)
                                         : VW'(item_r.intensity);
      end
      S_RDATA: begin
        sum_r   <= ram_rdata[RW-1 -: SW];
        cnt_r   <= ram_rdata[CW-1:0];
        value_r <= ram_rdata[RW-1 -: SW];
      end
      S_MLO: mlo_r <= sum_r[CW-1:0] * int_scale_r;
      S_MHI: begin
        dvd_r <= num_full[8 +: abih_pkg::DVD_W];
        rem_r <= '0;
      end
      S_DIV: begin
        rem_r <= qbit ? trial - {1'b0, cnt_r} : trial;
        dvd_r <= {dvd_r[abih_pkg::DVD_W-2:0], qbit};
        if (step_r == 6'(abih_pkg::DVD_W - 1)) begin
          value_r <= (dvd_r[abih_pkg::DVD_W-2 -: (abih_pkg::DVD_W - SW)] != '0)
                   ? '1 : {dvd_r[SW-2:0], qbit};
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_data_r.bin_sum   <= sum_r;
          out_data_r.bin_count <= cnt_r;
          out_data_r.bin_value <= value_r;
        end
      end
      default: ;
    endcase
  end
endmodule

`default_nettype wire

FILE: design/abih_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abih_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module abih_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

`default_nettype wire

FILE: design/abih_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abih_checker
// Port-level checks of the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
module abih_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire [1:0] in_op,
  input wire       out_valid,
  input wire       out_ready
);
  // clearing pass holds off items right after reset
  a_reset_blocks: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("item accepted during RAM clear");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready &&
     (in_op == abih_pkg::OP_READ || in_op == abih_pkg::OP_READ_CLR)) |=> !in_ready)
    else $error("read item did not occupy the block");

  a_accum_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == abih_pkg::OP_ACCUM) |=> !$rose(out_valid))
    else $error("accumulate item produced a result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");
endmodule

bind angle_binned_intensity_histogram abih_checker u_abih_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.data.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

`default_nettype wire
